// ----- sv/bpp_pkg.sv -----
// Shared types and constants for the biosignal packet byte parser.
package bpp_pkg;

  // Framing bytes and packet layout.
  localparam logic [7:0] END_BYTE     = 8'hC0;
  localparam logic [7:0] START_BYTE   = 8'hA0;
  localparam int unsigned MAX_CHANNELS = 16;
  localparam int unsigned NUM_ACCEL    = 3;

  // Field widths.
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned VAL_W   = 24;
  localparam int unsigned LOSS_W  = 32;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [CNT_W-1:0] CHANNEL_COUNT_RESET = 5'd8;

  // Register indexes on the configuration port.
  localparam logic REG_CHANNEL_COUNT = 1'b0;

  // Parser states.
  typedef enum logic [2:0] {
    ST_HUNT   = 3'd0,
    ST_START  = 3'd1,
    ST_FRAME  = 3'd2,
    ST_CHAN   = 3'd3,
    ST_ACCEL  = 3'd4,
    ST_END    = 3'd5
  } parse_state_e;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_CHAN     = 3'd0,
    KIND_ACCEL    = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_BAD_END  = 3'd3,
    KIND_MISMATCH = 3'd4
  } kind_e;

  // One result beat.
  typedef struct packed {
    kind_e                    kind;
    logic [IDX_W-1:0]         index;
    logic signed [VAL_W-1:0]  value;
    logic [LOSS_W-1:0]        sync_loss_count;
  } bpp_res_t;

endpackage

// ----- sv/biosignal_packet_byte_parser.sv -----
// Top level of the biosignal packet byte parser.
// Output: a result is registered in the output register, or held in the skid stage while the output stalls.
// Throughput: one byte per cycle while input ready is high; the parser state updates in a single pass per byte.
// A stalled output buffers one more result in a skid stage before input ready drops.
// Reset is asynchronous and active low: parser hunts for the end byte, counters clear,
// and the channel count returns to 8. No clearing pass is needed after reset.
module biosignal_packet_byte_parser
  import bpp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              byte_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              kind_o,
  output logic [IDX_W-1:0]        index_o,
  output logic signed [VAL_W-1:0] value_o,
  output logic [LOSS_W-1:0]       sync_loss_count_o
);

  logic             beat;
  logic             res_valid;
  logic [CNT_W-1:0] channel_count;
  bpp_res_t         res;
  bpp_res_t         out_data;

  assign beat = in_valid_i & in_ready_o;

  // Configuration registers.
  bpp_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .channel_count_o (channel_count)
  );

  // Packet parser.
  bpp_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .beat_i          (beat),
    .byte_in_i       (byte_in_i),
    .channel_count_i (channel_count),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // Result register and skid stage.
  bpp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (beat & res_valid),
    .push_data_i (res),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign kind_o            = out_data.kind;
  assign index_o           = out_data.index;
  assign value_o           = out_data.value;
  assign sync_loss_count_o = out_data.sync_loss_count;

endmodule

// ----- sv/bpp_regs.sv -----
// Configuration register file with an APB-style write and read port.
module bpp_regs
  import bpp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  channel_count_o
);

  logic [CNT_W-1:0] channel_count_q;
  logic             wr_en;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Register write on the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= CHANNEL_COUNT_RESET;
    end else if (wr_en && (reg_idx == REG_CHANNEL_COUNT)) begin
      channel_count_q <= pwdata[CNT_W-1:0];
    end
  end

  // Read mux; register indexes past the register list (paddr[2] set) read as zero.
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CHANNEL_COUNT) begin
      prdata = {{(DATA_W-CNT_W){1'b0}}, channel_count_q};
    end
  end

  assign channel_count_o = channel_count_q;

endmodule

// ----- sv/bpp_parse.sv -----
// Byte-level packet parser: framing state, value assembly and sync-loss count.
module bpp_parse
  import bpp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [7:0]       byte_in_i,
  input  logic [CNT_W-1:0] channel_count_i,
  output logic             res_valid_o,
  output bpp_res_t         res_o
);

  parse_state_e      state_q, state_d;
  logic [1:0]        bidx_q, bidx_d;
  logic [IDX_W-1:0]  vidx_q, vidx_d;
  logic [15:0]       acc_q, acc_d;
  logic [7:0]        frame_q, frame_d;
  logic [LOSS_W-1:0] loss_q, loss_d;
  logic [IDX_W-1:0]  n_chan;
  logic [IDX_W-1:0]  vidx_inc;
  logic [15:0]       accel_raw;

  // Clamp the channel count to the supported range.
  always_comb begin
    n_chan = channel_count_i;
    if (channel_count_i == '0) begin
      n_chan = IDX_W'(1);
    end else if (channel_count_i > CNT_W'(MAX_CHANNELS)) begin
      n_chan = IDX_W'(MAX_CHANNELS);
    end
  end

  assign vidx_inc  = vidx_q + IDX_W'(1);
  assign accel_raw = {acc_q[15:8], byte_in_i};

  // Next state, assembly and result for the incoming byte.
  always_comb begin
    state_d     = state_q;
    bidx_d      = bidx_q;
    vidx_d      = vidx_q;
    acc_d       = acc_q;
    frame_d     = frame_q;
    loss_d      = loss_q;
    res_valid_o = 1'b0;
    res_o.kind  = KIND_CHAN;
    res_o.index = '0;
    res_o.value = '0;
    case (state_q)
      ST_HUNT: begin
        if (byte_in_i == END_BYTE) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        state_d = (byte_in_i == START_BYTE) ? ST_FRAME : ST_HUNT;
      end
      ST_FRAME: begin
        frame_d = frame_q + 8'd1;
        bidx_d  = '0;
        vidx_d  = '0;
        acc_d   = '0;
        state_d = ST_CHAN;
        if (byte_in_i != frame_q) begin
          loss_d      = loss_q + LOSS_W'(1);
          res_valid_o = 1'b1;
          res_o.kind  = KIND_MISMATCH;
          res_o.value = {16'h0000, byte_in_i};
        end
      end
      ST_CHAN: begin
        if (bidx_q == 2'd2) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_CHAN;
          res_o.index = vidx_q;
          res_o.value = {acc_q, byte_in_i};
          vidx_d      = vidx_inc;
          bidx_d      = '0;
          acc_d       = '0;
          if (vidx_inc >= n_chan) begin
            state_d = ST_ACCEL;
          end
        end else begin
          bidx_d = bidx_q + 2'd1;
          acc_d  = (bidx_q == 2'd0) ? {byte_in_i, 8'h00} : {acc_q[15:8], byte_in_i};
        end
      end
      ST_ACCEL: begin
        if (bidx_q == 2'd0) begin
          acc_d  = {byte_in_i, 8'h00};
          bidx_d = 2'd1;
        end else begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_ACCEL;
          res_o.index = vidx_q;
          res_o.value = {{(VAL_W-16){accel_raw[15]}}, accel_raw};
          vidx_d      = vidx_inc;
          bidx_d      = '0;
          acc_d       = '0;
          if (vidx_inc >= IDX_W'(n_chan + IDX_W'(NUM_ACCEL))) begin
            vidx_d  = '0;
            state_d = ST_END;
          end
        end
      end
      ST_END: begin
        res_valid_o = 1'b1;
        if (byte_in_i == END_BYTE) begin
          state_d    = ST_START;
          res_o.kind = KIND_DONE;
        end else begin
          loss_d      = loss_q + LOSS_W'(1);
          state_d     = ST_HUNT;
          res_o.kind  = KIND_BAD_END;
          res_o.value = {16'h0000, byte_in_i};
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
    res_o.sync_loss_count = loss_d;
  end

  // Parser state, updated once per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      bidx_q  <= '0;
      vidx_q  <= '0;
      acc_q   <= '0;
      frame_q <= '0;
      loss_q  <= '0;
    end else if (beat_i) begin
      state_q <= state_d;
      bidx_q  <= bidx_d;
      vidx_q  <= vidx_d;
      acc_q   <= acc_d;
      frame_q <= frame_d;
      loss_q  <= loss_d;
    end
  end

  // A sync-loss result always bumps the counter by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && res_valid_o &&
    (res_o.kind == KIND_BAD_END || res_o.kind == KIND_MISMATCH)
    |=> loss_q == $past(loss_q) + LOSS_W'(1))
    else $error("loss counter did not advance on a sync loss");

  // Without a sync-loss result the counter holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(beat_i && res_valid_o &&
      (res_o.kind == KIND_BAD_END || res_o.kind == KIND_MISMATCH))
    |=> $stable(loss_q))
    else $error("loss counter changed without a sync loss");

  // The frame number byte always leads into channel assembly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && state_q == ST_FRAME |=> state_q == ST_CHAN && bidx_q == 2'd0)
    else $error("frame byte did not start channel assembly");

endmodule

// ----- sv/bpp_skid.sv -----
// Output register with a skid stage, so one more result is taken under backpressure before ready drops.
module bpp_skid
  import bpp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  bpp_res_t push_data_i,
  output logic     ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bpp_res_t out_data_o
);

  logic     out_valid_q;
  logic     skid_valid_q;
  bpp_res_t out_q;
  bpp_res_t skid_q;
  logic     out_free;

  assign ready_o  = ~skid_valid_q;
  assign out_free = ~out_valid_q | out_ready_i;

  // Control: the skid entry drains first, then new results go straight out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The skid entry is only ever filled behind a waiting output beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

endmodule
